### rtl/inverse_normal_cdf_approx_core_assert.svh
// Assertion macros shared by the inverse normal CDF core.
`ifndef INVERSE_NORMAL_CDF_APPROX_CORE_ASSERT_SVH
`define INVERSE_NORMAL_CDF_APPROX_CORE_ASSERT_SVH

// Same-cycle implication under the asynchronous active-low reset.
`define ICDF_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication under the asynchronous active-low reset.
`define ICDF_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/icdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icdf_pkg
// Widths, Q4.28 constants and stage positions of the inverse normal CDF core.
// ----------------------------------------------------------------------------
package icdf_pkg;

    localparam int PROB_WIDTH = 32;
    localparam int FRAC       = 28;
    localparam int EXP_W      = $clog2(PROB_WIDTH);
    localparam int LOG_ITERS  = FRAC;
    localparam int SQRT_ITERS = 32;
    localparam int DIV_ITERS  = 32;

    localparam logic [63:0] C0_Q = ((64'd2515517 << FRAC) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] C1_Q = ((64'd802853 << FRAC) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] C2_Q = ((64'd10328 << FRAC) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D1_Q = ((64'd1432788 << FRAC) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D2_Q = ((64'd189269 << FRAC) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D3_Q = ((64'd1308 << FRAC) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] TWO_LN2_Q = 64'd372130559;
    localparam logic [63:0] ONE_Q     = 64'd1 << FRAC;
    localparam logic [63:0] HALF_Q    = 64'd1 << (FRAC - 1);

    // Pipeline stage positions.
    localparam int ST_LOG0 = 2;
    localparam int ST_Y    = ST_LOG0 + LOG_ITERS + 1;
    localparam int ST_SQ0  = ST_Y + 2;
    localparam int ST_H1   = ST_SQ0 + SQRT_ITERS + 1;
    localparam int ST_DV0  = ST_H1 + 6;
    localparam int ST_F1   = ST_DV0 + DIV_ITERS + 1;
    localparam int NUM_ST  = ST_F1 + 2;

    // Index of the highest set bit, zero for a zero word.
    function automatic logic [EXP_W-1:0] top_bit(input logic [PROB_WIDTH-1:0] v);
        logic [EXP_W-1:0] idx;
        idx = '0;
        for (int i = 1; i < PROB_WIDTH; i++) begin
            if (v[i]) begin
                idx = EXP_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### rtl/inverse_normal_cdf_approx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_normal_cdf_approx_core
// Streaming inverse standard normal CDF (Abramowitz-Stegun 26.2.23).
// ----------------------------------------------------------------------------
// The core maps a probability p (unsigned Q0.32 on s_tdata) to the standard
// normal quantile z (signed Q4.27 on m_tdata); m_tuser flags p = 0, for which
// z is returned as zero. A new transaction is accepted every clock cycle
// while the output side is not stalled, and each one produces exactly one
// result. The pipeline lays out the three bit-serial units as stages: 28
// squaring stages for the base-2 logarithm, 32 stages of restoring square
// root and 32 stages of restoring division, plus normalization, the Horner
// multiplies and the final rounding. The whole pipeline advances together
// whenever the output register is empty or its result is being taken, so a
// stall on the output side holds every stage and loses nothing.
module inverse_normal_cdf_approx_core
    import icdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] p_fraction
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] z_score
    output logic        m_tuser    // [0] invalid_input
);

`include "inverse_normal_cdf_approx_core_assert.svh"

    logic en;

    // Control that travels with every item.
    logic [NUM_ST-1:0] vld_reg;
    logic [NUM_ST-1:0] lower_reg;
    logic [NUM_ST-1:0] inv_reg;

    // Front end: tail selection, exponent, mantissa.
    logic [PROB_WIDTH-1:0] p_in;
    logic                  lower_in;
    logic [PROB_WIDTH-1:0] k_next;
    logic [PROB_WIDTH-1:0] k0_reg;
    logic [PROB_WIDTH-1:0] k1_reg;
    logic [EXP_W-1:0]      e1_reg;
    logic [30:0]           m_next;

    // Logarithm by repeated squaring.
    logic [30:0]      lg_m_reg [0:LOG_ITERS];
    logic [FRAC-1:0]  lg_f_reg [0:LOG_ITERS];
    logic [EXP_W-1:0] lg_e_reg [0:LOG_ITERS];
    logic [30:0]      lg_m_next [0:LOG_ITERS-1];
    logic [FRAC-1:0]  lg_f_next [0:LOG_ITERS-1];

    logic [33:0] y_reg;
    logic [62:0] prod_reg;

    // Square root.
    logic [63:0] sq_rem_reg [0:SQRT_ITERS];
    logic [63:0] sq_res_reg [0:SQRT_ITERS];
    logic [63:0] sq_rem_next [0:SQRT_ITERS-1];
    logic [63:0] sq_res_next [0:SQRT_ITERS-1];

    // Rational part.
    logic [31:0] t_h;
    logic [31:0] h1_t_reg, h2_t_reg, h3_t_reg, h4_t_reg, h5_t_reg, h6_t_reg;
    logic [63:0] h1_a_reg, h1_b_reg;
    logic [33:0] h2_n_reg, h2_d_reg;
    logic [63:0] h3_a_reg, h3_b_reg;
    logic [33:0] h4_n_reg, h4_d_reg;
    logic [33:0] h5_n_reg;
    logic [63:0] h5_c_reg;
    logic [33:0] h6_n_reg, h6_d_reg;
    logic [63:0] dvd_next;

    // Division.
    logic [33:0] dv_rem_reg [0:DIV_ITERS];
    logic [31:0] dv_lo_reg  [0:DIV_ITERS];
    logic [31:0] dv_q_reg   [0:DIV_ITERS];
    logic [33:0] dv_den_reg [0:DIV_ITERS];
    logic [31:0] dv_t_reg   [0:DIV_ITERS];
    logic [33:0] dv_rem_next [0:DIV_ITERS-1];
    logic [31:0] dv_q_next   [0:DIV_ITERS-1];

    // Output.
    logic [31:0] f1_mag_reg;
    logic        f1_neg_reg;
    logic [31:0] z_reg;
    logic [31:0] mag_rnd;
    logic        neg_fin;

    assign en       = !vld_reg[NUM_ST-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NUM_ST-1];
    assign m_tdata  = z_reg;
    assign m_tuser  = inv_reg[NUM_ST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NUM_ST-2:0], s_tvalid};
        end
    end

    // The lower-tail half maps to k = p; the upper half to 2^32 - p. A zero p
    // is steered to k = 1 so the datapath stays in range; its result is
    // replaced at the output.
    always_comb
    begin
        p_in     = s_tdata[PROB_WIDTH-1:0];
        lower_in = !p_in[PROB_WIDTH-1];
        if (p_in == '0)
        begin
            k_next = PROB_WIDTH'(1);
        end
        else if (lower_in)
        begin
            k_next = p_in;
        end
        else
        begin
            k_next = '0 - p_in;
        end
        if (e1_reg >= EXP_W'(30))
        begin
            m_next = 31'(k1_reg >> (e1_reg - EXP_W'(30)));
        end
        else
        begin
            m_next = 31'(k1_reg << (EXP_W'(30) - e1_reg));
        end
    end

    always_comb
    begin
        for (int i = 0; i < LOG_ITERS; i++)
        begin
            logic [61:0] sq;
            logic [31:0] s;
            sq = 62'(lg_m_reg[i]) * 62'(lg_m_reg[i]);
            s  = sq[61:30];
            if (s[31])
            begin
                lg_m_next[i] = s[31:1];
                lg_f_next[i] = {lg_f_reg[i][FRAC-2:0], 1'b1};
            end
            else
            begin
                lg_m_next[i] = s[30:0];
                lg_f_next[i] = {lg_f_reg[i][FRAC-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < SQRT_ITERS; i++)
        begin
            logic [63:0] bitv;
            logic [63:0] trial;
            bitv  = 64'd1 << (62 - 2 * i);
            trial = sq_res_reg[i] + bitv;
            if (sq_rem_reg[i] >= trial)
            begin
                sq_rem_next[i] = sq_rem_reg[i] - trial;
                sq_res_next[i] = (sq_res_reg[i] >> 1) + bitv;
            end
            else
            begin
                sq_rem_next[i] = sq_rem_reg[i];
                sq_res_next[i] = sq_res_reg[i] >> 1;
            end
        end
    end

    assign t_h      = sq_res_reg[SQRT_ITERS][31:0];
    assign dvd_next = (64'(h6_n_reg) << FRAC) + 64'(h6_d_reg >> 1);

    always_comb
    begin
        for (int i = 0; i < DIV_ITERS; i++)
        begin
            logic [34:0] trial;
            trial = {dv_rem_reg[i], dv_lo_reg[i][31]};
            if (trial >= {1'b0, dv_den_reg[i]})
            begin
                dv_rem_next[i] = 34'(trial - {1'b0, dv_den_reg[i]});
                dv_q_next[i]   = {dv_q_reg[i][30:0], 1'b1};
            end
            else
            begin
                dv_rem_next[i] = trial[33:0];
                dv_q_next[i]   = {dv_q_reg[i][30:0], 1'b0};
            end
        end
    end

    // Halve the magnitude with rounding, then apply the tail sign.
    always_comb
    begin
        mag_rnd = 32'((33'(f1_mag_reg) + 33'd1) >> 1);
        neg_fin = f1_neg_reg ^ lower_reg[ST_F1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lower_reg <= {lower_reg[NUM_ST-2:0], lower_in};
            inv_reg   <= {inv_reg[NUM_ST-2:0], (p_in == '0)};

            k0_reg <= k_next;
            k1_reg <= k0_reg;
            e1_reg <= top_bit(k0_reg);

            lg_m_reg[0] <= m_next;
            lg_f_reg[0] <= '0;
            lg_e_reg[0] <= e1_reg;
            for (int i = 0; i < LOG_ITERS; i++)
            begin
                lg_m_reg[i+1] <= lg_m_next[i];
                lg_f_reg[i+1] <= lg_f_next[i];
                lg_e_reg[i+1] <= lg_e_reg[i];
            end

            y_reg    <= (34'(PROB_WIDTH - int'(lg_e_reg[LOG_ITERS])) << FRAC)
                        - 34'(lg_f_reg[LOG_ITERS]);
            prod_reg <= 63'(y_reg) * 63'(TWO_LN2_Q);

            sq_rem_reg[0] <= ((64'(prod_reg) + HALF_Q) >> FRAC) << FRAC;
            sq_res_reg[0] <= '0;
            for (int i = 0; i < SQRT_ITERS; i++)
            begin
                sq_rem_reg[i+1] <= sq_rem_next[i];
                sq_res_reg[i+1] <= sq_res_next[i];
            end

            h1_t_reg <= t_h;
            h1_a_reg <= C2_Q * 64'(t_h);
            h1_b_reg <= D3_Q * 64'(t_h);

            h2_t_reg <= h1_t_reg;
            h2_n_reg <= 34'((h1_a_reg >> FRAC) + C1_Q);
            h2_d_reg <= 34'((h1_b_reg >> FRAC) + D2_Q);

            h3_t_reg <= h2_t_reg;
            h3_a_reg <= 64'(h2_n_reg) * 64'(h2_t_reg);
            h3_b_reg <= 64'(h2_d_reg) * 64'(h2_t_reg);

            h4_t_reg <= h3_t_reg;
            h4_n_reg <= 34'((h3_a_reg >> FRAC) + C0_Q);
            h4_d_reg <= 34'((h3_b_reg >> FRAC) + D1_Q);

            h5_t_reg <= h4_t_reg;
            h5_n_reg <= h4_n_reg;
            h5_c_reg <= 64'(h4_d_reg) * 64'(h4_t_reg);

            h6_t_reg <= h5_t_reg;
            h6_n_reg <= h5_n_reg;
            h6_d_reg <= 34'((h5_c_reg >> FRAC) + ONE_Q);

            dv_rem_reg[0] <= dvd_next[63:32] & 34'hFFFF_FFFF;
            dv_lo_reg[0]  <= dvd_next[31:0];
            dv_q_reg[0]   <= '0;
            dv_den_reg[0] <= h6_d_reg;
            dv_t_reg[0]   <= h6_t_reg;
            for (int i = 0; i < DIV_ITERS; i++)
            begin
                dv_rem_reg[i+1] <= dv_rem_next[i];
                dv_lo_reg[i+1]  <= {dv_lo_reg[i][30:0], 1'b0};
                dv_q_reg[i+1]   <= dv_q_next[i];
                dv_den_reg[i+1] <= dv_den_reg[i];
                dv_t_reg[i+1]   <= dv_t_reg[i];
            end

            if (dv_t_reg[DIV_ITERS] >= dv_q_reg[DIV_ITERS])
            begin
                f1_mag_reg <= dv_t_reg[DIV_ITERS] - dv_q_reg[DIV_ITERS];
                f1_neg_reg <= 1'b0;
            end
            else
            begin
                f1_mag_reg <= dv_q_reg[DIV_ITERS] - dv_t_reg[DIV_ITERS];
                f1_neg_reg <= 1'b1;
            end

            if (inv_reg[ST_F1])
            begin
                z_reg <= '0;
            end
            else if (neg_fin)
            begin
                z_reg <= '0 - mag_rnd;
            end
            else
            begin
                z_reg <= mag_rnd;
            end
        end
    end

    // A zero probability is flagged in the first stage.
    `ICDF_ASSERT_NEXT(a_zero_flagged, clk, rst_n,
        s_tvalid && s_tready && (s_tdata == 32'd0), vld_reg[0] && inv_reg[0])

    // A flagged result always carries a zero quantile.
    `ICDF_ASSERT_IMPL(a_invalid_zero, clk, rst_n, m_tvalid && m_tuser, m_tdata == 32'd0)

    // The division keeps its partial remainder below the divisor.
    `ICDF_ASSERT_IMPL(a_div_rem, clk, rst_n, vld_reg[ST_DV0 + 1],
        dv_rem_reg[1] < dv_den_reg[1])

    // The square root result stays below 8 in Q.28.
    `ICDF_ASSERT_IMPL(a_sqrt_range, clk, rst_n, vld_reg[ST_H1], !h1_t_reg[31])

endmodule

### test/inverse_normal_cdf_approx_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_normal_cdf_approx_core_tb
// Self-checking testbench for the streaming inverse normal CDF core.
// ----------------------------------------------------------------------------
// Probabilities are driven on the slave stream and every result is compared
// with a quantile computed here in fixed point. The directed tests cover the
// edges of the input range, and the random tests cover tails and centre.
// Both the sender and the receiver idle at random.
// ----------------------------------------------------------------------------
module inverse_normal_cdf_approx_core_tb;
    import icdf_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 150;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // [31:0] p_fraction
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // [31:0] z_score
    logic        m_tuser;   // [0] invalid_input

    typedef struct packed {
        logic [31:0] z_score;
        logic        invalid_input;
    } quantile_t;

    quantile_t quantile_queue[$];
    int        error_count;
    int        idle_cycles;
    bit        timed_out;
    int        burst_left;

    inverse_normal_cdf_approx_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Integer square root, floor, by the restoring method.
    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        rem  = x;
        res  = '0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Expected quantile for one probability.
    function automatic quantile_t predict_quantile(input logic [31:0] p);
        quantile_t   q;
        logic [63:0] k, m, f, y, u, t, num, den, ratio, mag;
        int          e;
        bit          lower, neg;
        q = '0;
        if (p == 32'd0)
        begin
            q.invalid_input = 1'b1;
            return q;
        end
        lower = !p[31];
        k     = lower ? {32'd0, p} : (64'd1 << 32) - {32'd0, p};
        e     = 0;
        for (int i = 1; i < 64; i++)
        begin
            if (k[i])
            begin
                e = i;
            end
        end
        m = (e >= 30) ? (k >> (e - 30)) : (k << (30 - e));
        f = '0;
        // Each squaring of the mantissa yields one fraction bit of log2.
        for (int i = 0; i < FRAC; i++)
        begin
            m = (m * m) >> 30;
            f = f << 1;
            if (m >= (64'd2 << 30))
            begin
                f[0] = 1'b1;
                m    = m >> 1;
            end
        end
        y     = (64'(PROB_WIDTH - e) << FRAC) - f;
        u     = (y * TWO_LN2_Q + HALF_Q) >> FRAC;
        t     = isqrt(u << FRAC);
        num   = ((C2_Q * t) >> FRAC) + C1_Q;
        num   = ((num * t) >> FRAC) + C0_Q;
        den   = ((D3_Q * t) >> FRAC) + D2_Q;
        den   = ((den * t) >> FRAC) + D1_Q;
        den   = ((den * t) >> FRAC) + ONE_Q;
        ratio = ((num << FRAC) + (den >> 1)) / den;
        if (t >= ratio)
        begin
            mag = t - ratio;
            neg = 1'b0;
        end
        else
        begin
            mag = ratio - t;
            neg = 1'b1;
        end
        mag = (mag + 64'd1) >> 1;
        if (lower)
        begin
            neg = !neg;
        end
        q.z_score = neg ? (32'd0 - mag[31:0]) : mag[31:0];
        return q;
    endfunction

    // Send one probability, honoring the burst and gap pattern.
    task automatic send_probability(input logic [31:0] p);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 12)) : 0;
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        quantile_queue.push_back(predict_quantile(p));
        burst_left--;
        @(negedge clk);
    endtask

    // Drop valid and let the idle cycle take effect before anything else.
    task automatic end_burst();
        s_tvalid   <= 1'b0;
        burst_left = 0;
        @(negedge clk);
    endtask

    // Random probability biased toward the far tails and the centre.
    function automatic logic [31:0] random_probability();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return $urandom >> $urandom_range(0, 31);
            1: return 32'hFFFF_FFFF - ($urandom >> $urandom_range(0, 31));
            2: return 32'h8000_0000 + $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed_edges();
        logic [31:0] edges[$];
        edges = '{32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003,
                  32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0001, 32'h4000_0000, 32'hC000_0000, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_0000,
                  32'h8000_FFFF, 32'h1000_0000, 32'hF000_0000, 32'h0000_0000};
        foreach (edges[i])
        begin
            send_probability(edges[i]);
        end
        end_burst();
    endtask

    // The sender holds off until every result in flight has come back.
    task automatic test_drain_pause();
        while (quantile_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (5) send_probability(random_probability());
        end_burst();
    endtask

    task automatic test_random_stream(input int count);
        for (int i = 0; i < count; i++)
        begin
            send_probability(random_probability());
        end
        end_burst();
    endtask

    // Result checker: compares each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        quantile_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (quantile_queue.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual z=%h inv=%b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end
            else
            begin
                want = quantile_queue.pop_front();
                if (m_tdata !== want.z_score)
                begin
                    $display("%0t: z_score mismatch expected %h actual %h",
                             $time, want.z_score, m_tdata);
                    error_count++;
                end
                if (m_tuser !== want.invalid_input)
                begin
                    $display("%0t: invalid_input mismatch expected %b actual %b",
                             $time, want.invalid_input, m_tuser);
                    error_count++;
                end
            end
        end
    end

    // Receiver stall pattern, changed at the falling edge; phases of free flow.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if ((($time / 4000) % 3) == 0)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Watchdog on cycles with no accepted transaction on either side.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("inverse_normal_cdf_approx_core verification failed");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        timed_out   = 1'b0;
        burst_left  = 0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        test_directed_edges();
        test_drain_pause();
        test_random_stream(1700);
        while (quantile_queue.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (error_count == 0)
        begin
            $display("inverse_normal_cdf_approx_core verification clean");
        end
        else
        begin
            $display("inverse_normal_cdf_approx_core verification failed");
        end
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/icdf_pkg.sv
rtl/inverse_normal_cdf_approx_core.sv
test/inverse_normal_cdf_approx_core_tb.sv
